>>> design/msblit_pkg.sv
`timescale 1ns / 1ps
package msblit_pkg;

	// default geometry
	localparam int SPRITE_SLOTS_DEF = 64;
	localparam int SPRITE_ROWS_DEF  = 64;
	localparam int FB_WORDS_DEF     = 8192;

	// fixed geometry
	localparam int SPRITE_ROW_WORDS = 4;
	localparam int FB_ROW_WORDS     = 32;
	localparam int FB_ROW_SHIFT     = 5;
	localparam int WORD_W           = 16;
	localparam int SHIFT_W          = 4;
	localparam int DRAW_WORDS       = 5;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_CLEAR = 2'd1,
		OP_DRAW  = 2'd2,
		OP_READ  = 2'd3
	} opc_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_ROW,
		S_FRD,
		S_FWR,
		S_RWAIT,
		S_OUT
	} bstate_t;

endpackage

>>> design/msblit_cmd_if.sv
`timescale 1ns / 1ps
interface msblit_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [5:0]  sprite_index;
	logic [5:0]  sprite_row;
	logic [1:0]  sprite_word;
	logic [15:0] alpha_word;
	logic [15:0] color_word;
	logic        clear_color;
	logic [8:0]  pos_x;
	logic [7:0]  pos_y;
	logic [12:0] fb_address;

	modport source (
		output valid, opcode, sprite_index, sprite_row, sprite_word, alpha_word,
			color_word, clear_color, pos_x, pos_y, fb_address,
		input  ready
	);
	modport sink (
		input  valid, opcode, sprite_index, sprite_row, sprite_word, alpha_word,
			color_word, clear_color, pos_x, pos_y, fb_address,
		output ready
	);
endinterface

>>> design/msblit_res_if.sv
`timescale 1ns / 1ps
interface msblit_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;

	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

>>> design/msblit_front.sv
`timescale 1ns / 1ps
module msblit_front import msblit_pkg::*; #(
	parameter int SPRITE_SLOTS = SPRITE_SLOTS_DEF,
	parameter int SPRITE_ROWS  = SPRITE_ROWS_DEF,
	parameter int FB_WORDS     = FB_WORDS_DEF,
	localparam int SA_N = SPRITE_SLOTS * SPRITE_ROWS,
	localparam int SA_W = (SA_N > 1) ? $clog2(SA_N) : 1,
	localparam int DA_W = $clog2(256 * FB_ROW_WORDS + SPRITE_ROWS * FB_ROW_WORDS + 8)
) (
	input  logic              clk,
	input  logic              arst_n,
	msblit_cmd_if.sink        cmd,
	output logic              q_valid,
	input  logic              q_pop,
	output opc_t              q_op,
	output logic              q_ok,
	output logic [SA_W-1:0]   q_sa,
	output logic [1:0]        q_lane,
	output logic [WORD_W-1:0] q_alpha,
	output logic [WORD_W-1:0] q_color,
	output logic              q_fill,
	output logic [DA_W-1:0]   q_fbase,
	output logic [SHIFT_W-1:0] q_shift,
	output logic [12:0]       q_raddr
);

	// two-entry command queue
	opc_t              op_q    [2];
	logic              ok_q    [2];
	logic [SA_W-1:0]   sa_q    [2];
	logic [1:0]        lane_q  [2];
	logic [WORD_W-1:0] alpha_q [2];
	logic [WORD_W-1:0] color_q [2];
	logic              fill_q  [2];
	logic [DA_W-1:0]   fbase_q [2];
	logic [SHIFT_W-1:0] shift_q [2];
	logic [12:0]       raddr_q [2];
	logic              wptr_q, rptr_q;
	logic [1:0]        cnt_q;

	opc_t              op_in;
	logic              ok_in;
	logic [SA_W-1:0]   sa_in;
	logic [DA_W-1:0]   fbase_in;
	logic              push;

	// classify the incoming transaction
	always_comb begin
		op_in = opc_t'(cmd.opcode);
		case (op_in)
			OP_WRITE: ok_in = (32'(cmd.sprite_index) < SPRITE_SLOTS) &&
				(32'(cmd.sprite_row) < SPRITE_ROWS);
			OP_DRAW:  ok_in = 32'(cmd.sprite_index) < SPRITE_SLOTS;
			OP_READ:  ok_in = 32'(cmd.fb_address) < FB_WORDS;
			default:  ok_in = 1'b1;
		endcase
		sa_in = SA_W'(32'(cmd.sprite_index) * SPRITE_ROWS +
			((op_in == OP_WRITE) ? 32'(cmd.sprite_row) : 32'd0));
		fbase_in = (DA_W'(cmd.pos_y) << FB_ROW_SHIFT) + DA_W'(cmd.pos_x[8:4]);
	end

	assign cmd.ready = (cnt_q != 2'd2);
	assign push      = cmd.valid && cmd.ready;

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (q_pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wptr_q]    <= op_in;
			ok_q[wptr_q]    <= ok_in;
			sa_q[wptr_q]    <= sa_in;
			lane_q[wptr_q]  <= cmd.sprite_word;
			alpha_q[wptr_q] <= cmd.alpha_word;
			color_q[wptr_q] <= cmd.color_word;
			fill_q[wptr_q]  <= cmd.clear_color;
			fbase_q[wptr_q] <= fbase_in;
			shift_q[wptr_q] <= cmd.pos_x[3:0];
			raddr_q[wptr_q] <= cmd.fb_address;
		end
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_op    = op_q[rptr_q];
	assign q_ok    = ok_q[rptr_q];
	assign q_sa    = sa_q[rptr_q];
	assign q_lane  = lane_q[rptr_q];
	assign q_alpha = alpha_q[rptr_q];
	assign q_color = color_q[rptr_q];
	assign q_fill  = fill_q[rptr_q];
	assign q_fbase = fbase_q[rptr_q];
	assign q_shift = shift_q[rptr_q];
	assign q_raddr = raddr_q[rptr_q];

endmodule

>>> design/msblit_back.sv
`timescale 1ns / 1ps
module msblit_back import msblit_pkg::*; #(
	parameter int SPRITE_SLOTS = SPRITE_SLOTS_DEF,
	parameter int SPRITE_ROWS  = SPRITE_ROWS_DEF,
	parameter int FB_WORDS     = FB_WORDS_DEF,
	localparam int SA_N = SPRITE_SLOTS * SPRITE_ROWS,
	localparam int SA_W = (SA_N > 1) ? $clog2(SA_N) : 1,
	localparam int DA_W = $clog2(256 * FB_ROW_WORDS + SPRITE_ROWS * FB_ROW_WORDS + 8)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_pop,
	input  opc_t              q_op,
	input  logic              q_ok,
	input  logic [SA_W-1:0]   q_sa,
	input  logic [1:0]        q_lane,
	input  logic [WORD_W-1:0] q_alpha,
	input  logic [WORD_W-1:0] q_color,
	input  logic              q_fill,
	input  logic [DA_W-1:0]   q_fbase,
	input  logic [SHIFT_W-1:0] q_shift,
	input  logic [12:0]       q_raddr,
	msblit_res_if.source      res
);

	localparam int FA_W = $clog2(FB_WORDS);
	localparam int RW_W = (SPRITE_ROWS > 1) ? $clog2(SPRITE_ROWS) : 1;

	bstate_t            state_q, state_d;
	logic [FA_W-1:0]    cnt_q, cnt_d;
	logic [RW_W-1:0]    row_q, row_d;
	logic [2:0]         k_q, k_d;
	logic [DA_W-1:0]    base_q, base_d;
	logic [SA_W-1:0]    sa_q, sa_d;
	logic [SHIFT_W-1:0] shift_q, shift_d;
	logic               fill_q, fill_d;
	logic [WORD_W-1:0]  res_q, res_d;

	// memories
	logic [WORD_W-1:0]  fb_mem [FB_WORDS];
	logic [WORD_W-1:0]  fb_rd_q;
	logic [WORD_W-1:0]  spr_rd_a [SPRITE_ROW_WORDS];
	logic [WORD_W-1:0]  spr_rd_c [SPRITE_ROW_WORDS];

	logic               fb_we, fb_re;
	logic [FA_W-1:0]    fb_wa, fb_ra;
	logic [WORD_W-1:0]  fb_wd;
	logic               spr_we, spr_re;
	logic [SA_W-1:0]    spr_wa, spr_ra;

	logic [DA_W-1:0]    cur_addr;
	logic               addr_ok;
	logic [WORD_W-1:0]  prev_a, cur_a, prev_c, cur_c, am, cm;
	logic [2*WORD_W-1:0] sh_a, sh_c;

	// frame buffer, one write and one registered read port
	always_ff @(posedge clk) begin
		if (fb_we) fb_mem[fb_wa] <= fb_wd;
		if (fb_re) fb_rd_q <= fb_mem[fb_ra];
	end

	// sprite memory, one lane per word of a row
	for (genvar g = 0; g < SPRITE_ROW_WORDS; g++) begin : g_lane
		logic [WORD_W-1:0] mem_a [SA_N];
		logic [WORD_W-1:0] mem_c [SA_N];
		always_ff @(posedge clk) begin
			if (spr_we && (q_lane == 2'(g))) begin
				mem_a[spr_wa] <= q_alpha;
				mem_c[spr_wa] <= q_color;
			end
			if (spr_re) begin
				spr_rd_a[g] <= mem_a[spr_ra];
				spr_rd_c[g] <= mem_c[spr_ra];
			end
		end
	end

	// shifted alpha and color for the current word of the row
	always_comb begin
		cur_addr = base_q + DA_W'(k_q);
		addr_ok  = 32'(cur_addr) < FB_WORDS;
		cur_a  = (k_q != 3'd4) ? spr_rd_a[k_q[1:0]] : '0;
		cur_c  = (k_q != 3'd4) ? spr_rd_c[k_q[1:0]] : '0;
		prev_a = (k_q != 3'd0) ? spr_rd_a[2'(k_q - 3'd1)] : '0;
		prev_c = (k_q != 3'd0) ? spr_rd_c[2'(k_q - 3'd1)] : '0;
		sh_a = {prev_a, cur_a} >> shift_q;
		sh_c = {prev_c, cur_c} >> shift_q;
		am = sh_a[WORD_W-1:0];
		cm = sh_c[WORD_W-1:0];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		cnt_q   <= cnt_d;
		row_q   <= row_d;
		k_q     <= k_d;
		base_q  <= base_d;
		sa_q    <= sa_d;
		shift_q <= shift_d;
		fill_q  <= fill_d;
		res_q   <= res_d;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		row_d   = row_q;
		k_d     = k_q;
		base_d  = base_q;
		sa_d    = sa_q;
		shift_d = shift_q;
		fill_d  = fill_q;
		res_d   = res_q;
		q_pop   = 1'b0;
		fb_we   = 1'b0;
		fb_re   = 1'b0;
		fb_wa   = FA_W'(cur_addr);
		fb_ra   = FA_W'(cur_addr);
		fb_wd   = (fb_rd_q & ~am) | (cm & am);
		spr_we  = 1'b0;
		spr_re  = 1'b0;
		spr_wa  = q_sa;
		spr_ra  = sa_q + SA_W'(row_q);
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_op)
						OP_WRITE: begin
							spr_we = q_ok;
						end
						OP_CLEAR: begin
							cnt_d   = '0;
							fill_d  = q_fill;
							state_d = S_CLEAR;
						end
						OP_DRAW: begin
							if (q_ok) begin
								sa_d    = q_sa;
								shift_d = q_shift;
								base_d  = q_fbase;
								row_d   = '0;
								state_d = S_ROW;
							end
						end
						OP_READ: begin
							if (q_ok) begin
								fb_re   = 1'b1;
								fb_ra   = FA_W'(q_raddr);
								state_d = S_RWAIT;
							end else begin
								res_d   = '0;
								state_d = S_OUT;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_CLEAR: begin
				fb_we = 1'b1;
				fb_wa = cnt_q;
				fb_wd = {WORD_W{fill_q}};
				if (cnt_q == FA_W'(FB_WORDS - 1)) begin
					state_d = S_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_ROW: begin
				spr_re  = 1'b1;
				k_d     = '0;
				state_d = S_FRD;
			end
			S_FRD: begin
				fb_re   = addr_ok;
				state_d = S_FWR;
			end
			S_FWR: begin
				fb_we = addr_ok;
				if (k_q == 3'(DRAW_WORDS - 1)) begin
					if (row_q == RW_W'(SPRITE_ROWS - 1)) begin
						state_d = S_IDLE;
					end else begin
						row_d   = row_q + 1'b1;
						base_d  = base_q + DA_W'(FB_ROW_WORDS);
						state_d = S_ROW;
					end
				end else begin
					k_d     = k_q + 3'd1;
					state_d = S_FRD;
				end
			end
			S_RWAIT: begin
				res_d   = fb_rd_q;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (res.ready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res.valid     = (state_q == S_OUT);
	assign res.read_data = res_q;

endmodule

>>> design/masked_sprite_blitter_1bpp_unit.sv
`timescale 1ns / 1ps
// 1bpp masked sprite blitter
// cmd channel: one transaction per command (write sprite word, clear frame,
// draw sprite, read frame word); res channel: one transaction per read only.
// commands go into a two-entry queue, so the sender keeps going while the
// execution side is busy or a read result waits to be taken.
// steps per command, as the sequencer runs them:
//   sprite write, the dispatch step only; frame read, the dispatch step reads
//   the word into the read register, it is copied to the result register, and
//   the result is offered on res until taken; clear, the dispatch step, then one
//   write per frame word; draw, the dispatch step, then per sprite row one
//   sprite row read, then a read and a write step for each of the five words.
// reset empties the queue and returns the sequencer to idle; sprite and frame
// memories are not cleared, so the frame must be cleared before it is read.
// when the receiver holds res.ready low the result stays registered and
// execution waits; the queue keeps accepting until it holds two commands.
module masked_sprite_blitter_1bpp_unit import msblit_pkg::*; #(
	parameter int SPRITE_SLOTS = SPRITE_SLOTS_DEF,
	parameter int SPRITE_ROWS  = SPRITE_ROWS_DEF,
	parameter int FB_WORDS     = FB_WORDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	msblit_cmd_if.sink   cmd,
	msblit_res_if.source res
);

	localparam int SA_N = SPRITE_SLOTS * SPRITE_ROWS;
	localparam int SA_W = (SA_N > 1) ? $clog2(SA_N) : 1;
	localparam int DA_W = $clog2(256 * FB_ROW_WORDS + SPRITE_ROWS * FB_ROW_WORDS + 8);

	logic               q_valid, q_pop, q_ok, q_fill;
	opc_t               q_op;
	logic [SA_W-1:0]    q_sa;
	logic [1:0]         q_lane;
	logic [WORD_W-1:0]  q_alpha, q_color;
	logic [DA_W-1:0]    q_fbase;
	logic [SHIFT_W-1:0] q_shift;
	logic [12:0]        q_raddr;

	// command decode and queue
	msblit_front #(
		.SPRITE_SLOTS(SPRITE_SLOTS),
		.SPRITE_ROWS (SPRITE_ROWS),
		.FB_WORDS    (FB_WORDS)
	) u_front (
		.clk, .arst_n, .cmd,
		.q_valid, .q_pop, .q_op, .q_ok, .q_sa, .q_lane, .q_alpha, .q_color,
		.q_fill, .q_fbase, .q_shift, .q_raddr
	);

	// execution and memories
	msblit_back #(
		.SPRITE_SLOTS(SPRITE_SLOTS),
		.SPRITE_ROWS (SPRITE_ROWS),
		.FB_WORDS    (FB_WORDS)
	) u_back (
		.clk, .arst_n,
		.q_valid, .q_pop, .q_op, .q_ok, .q_sa, .q_lane, .q_alpha, .q_color,
		.q_fill, .q_fbase, .q_shift, .q_raddr,
		.res
	);

endmodule
